// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while out of reset.
`define PSP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an antecedent is followed by a consequent in the next cycle.
`define PSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/psp_pkg.sv
// Types and constants of the proportional seek position unit.
package psp_pkg;

  localparam int unsigned TIME_BITS_DEF = 24;
  localparam int unsigned PCT_BITS      = 7;
  localparam int unsigned STEP_DIVISOR  = 60;
  localparam int unsigned PERCENT_FULL  = 100;
  localparam int unsigned STEP_MIN_RST  = 5;
  localparam int unsigned STEP_MAX_RST  = 60;

  typedef enum logic [1:0] {
    OP_RESET = 2'd0,
    OP_BEGIN = 2'd1,
    OP_MOVE  = 2'd2
  } op_e;

  typedef enum logic {
    CFG_STEP_MIN = 1'b0,
    CFG_STEP_MAX = 1'b1
  } cfg_e;

endpackage

// File: hdl/proportional_seek_position_unit.sv
// Proportional seek position unit: session state, step sequencer and percent divider.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------------
//  in       | in_valid_i / in_stall_o  | operation_i, elapsed_time_i, track_length_i,
//           |                          | direction_i
//  out      | out_valid_o / out_stall_i| accepted_o, session_active_o, target_time_o,
//           |                          | target_percent_o
//  cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// A stepping move computes length / 60 as one reciprocal multiply, then clamps, applies,
// and runs the restoring divider for the percent, one quotient bit per cycle. Reset,
// begin and ignored items go straight to the percent step; a zero length or a target at
// full length skips the divider. A new item is taken only while the sequencer is
// idle; a result waits in the output register under stall while the next item is at work,
// and that item holds in its last state until the register frees. Reset clears the session
// and loads the step registers with 5 and 60.
module proportional_seek_position_unit import psp_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           operation_i,
  input  logic [TIME_BITS-1:0] elapsed_time_i,
  input  logic [TIME_BITS-1:0] track_length_i,
  input  logic signed [1:0]    direction_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 session_active_o,
  output logic [TIME_BITS-1:0] target_time_o,
  output logic [PCT_BITS-1:0]  target_percent_o,
  // register writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [TIME_BITS-1:0] cfg_data_i
);

  localparam int unsigned DW = TIME_BITS + PCT_BITS;
  localparam int unsigned CW = $clog2(PCT_BITS + 1);
  // rounded-up reciprocal of 60, exact for every length of TIME_BITS bits
  localparam int unsigned RECIP_SH = TIME_BITS + $clog2(STEP_DIVISOR);
  localparam logic [TIME_BITS:0] RECIP =
    (TIME_BITS+1)'(((64'd1 << RECIP_SH) + 64'(STEP_DIVISOR) - 64'd1) / 64'(STEP_DIVISOR));

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DIV_STEP = 7'b0000010,
    S_CLAMP    = 7'b0000100,
    S_APPLY    = 7'b0001000,
    S_PCT      = 7'b0010000,
    S_DIV_PCT  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e               state_q, state_d;
  logic                 active_q, active_d;
  logic [TIME_BITS-1:0] length_q, length_d;
  logic [TIME_BITS-1:0] target_q, target_d;
  logic [TIME_BITS-1:0] step_min_q, step_min_d;
  logic [TIME_BITS-1:0] step_max_q, step_max_d;
  logic                 out_valid_q, out_valid_d;

  logic                 dir_back_q, dir_back_d;
  logic                 acc_q, acc_d;
  logic [TIME_BITS-1:0] rem_q, rem_d;
  logic [DW-1:0]        quo_q, quo_d;
  logic [TIME_BITS-1:0] dsr_q, dsr_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [TIME_BITS-1:0] step_q, step_d;
  logic [PCT_BITS-1:0]  pct_q, pct_d;
  logic                 out_acc_q, out_acc_d;
  logic                 out_active_q, out_active_d;
  logic [TIME_BITS-1:0] out_target_q, out_target_d;
  logic [PCT_BITS-1:0]  out_pct_q, out_pct_d;

  // percent divider step: one restoring iteration
  logic [TIME_BITS:0]   rem_sh;
  logic                 fits;
  logic [TIME_BITS:0]   rem_diff;
  logic [TIME_BITS-1:0] rem_nx;
  logic [DW-1:0]        quo_nx;

  assign rem_sh   = {rem_q, quo_q[DW-1]};
  assign fits     = rem_sh >= {1'b0, dsr_q};
  assign rem_diff = rem_sh - {1'b0, dsr_q};
  assign rem_nx   = fits ? rem_diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
  assign quo_nx   = {quo_q[DW-2:0], fits};

  // length / 60 as a multiply by the reciprocal
  logic [2*TIME_BITS:0] share_prod;
  assign share_prod = (2*TIME_BITS+1)'(length_q) * (2*TIME_BITS+1)'(RECIP);

  // target times one hundred as shifts and adds
  logic [DW-1:0] prod;
  assign prod = (DW'(target_q) << 6) + (DW'(target_q) << 5) + (DW'(target_q) << 2);

  // clamp of the share, then the saturating move
  logic [TIME_BITS-1:0] share;
  logic [TIME_BITS-1:0] room;
  logic [TIME_BITS-1:0] moved;
  assign share = quo_q[TIME_BITS-1:0];
  assign room  = length_q - target_q;

  always_comb begin
    if (dir_back_q) begin
      moved = (target_q < step_q) ? '0 : target_q - step_q;
    end else if (target_q >= length_q || room < step_q) begin
      moved = length_q;
    end else begin
      moved = target_q + step_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // sequencer and next-state logic
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    length_d     = length_q;
    target_d     = target_q;
    step_min_d   = step_min_q;
    step_max_d   = step_max_q;
    out_valid_d  = out_valid_q;
    dir_back_d   = dir_back_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    dsr_d        = dsr_q;
    cnt_d        = cnt_q;
    step_d       = step_q;
    pct_d        = pct_q;
    out_acc_d    = out_acc_q;
    out_active_d = out_active_q;
    out_target_d = out_target_q;
    out_pct_d    = out_pct_q;

    // register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STEP_MIN: step_min_d = cfg_data_i;
        CFG_STEP_MAX: step_max_d = cfg_data_i;
        default: ;
      endcase
    end

    // drop the result once its transfer completes
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          acc_d   = 1'b0;
          state_d = S_PCT;
          case (operation_i)
            OP_RESET: begin
              active_d = 1'b0;
              length_d = '0;
              target_d = '0;
              acc_d    = 1'b1;
            end
            OP_BEGIN: begin
              if (track_length_i != '0) begin
                active_d = 1'b1;
                length_d = track_length_i;
                target_d = (elapsed_time_i > track_length_i) ? track_length_i
                                                             : elapsed_time_i;
                acc_d    = 1'b1;
              end
            end
            OP_MOVE: begin
              dir_back_d = direction_i[1];
              if (active_q && direction_i != 2'sd0) begin
                state_d = S_DIV_STEP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV_STEP: begin
        quo_d   = DW'(share_prod[2*TIME_BITS:RECIP_SH]);
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        if (share < step_min_q) begin
          step_d = step_min_q;
        end else if (share > step_max_q) begin
          step_d = step_max_q;
        end else begin
          step_d = share;
        end
        state_d = S_APPLY;
      end
      S_APPLY: begin
        target_d = moved;
        acc_d    = (moved != target_q);
        state_d  = S_PCT;
      end
      S_PCT: begin
        if (length_q == '0) begin
          pct_d   = '0;
          state_d = S_DONE;
        end else if (target_q >= length_q) begin
          pct_d   = PCT_BITS'(PERCENT_FULL);
          state_d = S_DONE;
        end else begin
          rem_d   = prod[DW-1:PCT_BITS];
          quo_d   = {prod[PCT_BITS-1:0], {TIME_BITS{1'b0}}};
          dsr_d   = length_q;
          cnt_d   = CW'(PCT_BITS);
          state_d = S_DIV_PCT;
        end
      end
      S_DIV_PCT: begin
        rem_d = rem_nx;
        quo_d = quo_nx;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          pct_d   = quo_nx[PCT_BITS-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_acc_d    = acc_q;
          out_active_d = active_q;
          out_target_d = target_q;
          out_pct_d    = pct_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control and session state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      length_q    <= '0;
      target_q    <= '0;
      step_min_q  <= TIME_BITS'(STEP_MIN_RST);
      step_max_q  <= TIME_BITS'(STEP_MAX_RST);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      length_q    <= length_d;
      target_q    <= target_d;
      step_min_q  <= step_min_d;
      step_max_q  <= step_max_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    dir_back_q   <= dir_back_d;
    acc_q        <= acc_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    dsr_q        <= dsr_d;
    cnt_q        <= cnt_d;
    step_q       <= step_d;
    pct_q        <= pct_d;
    out_acc_q    <= out_acc_d;
    out_active_q <= out_active_d;
    out_target_q <= out_target_d;
    out_pct_q    <= out_pct_d;
  end

  assign out_valid_o      = out_valid_q;
  assign accepted_o       = out_acc_q;
  assign session_active_o = out_active_q;
  assign target_time_o    = out_target_q;
  assign target_percent_o = out_pct_q;

endmodule

// File: hdl/psp_checker.sv
// Port-level checker of the proportional seek position unit and its bind.
`include "assert_macros.svh"

module psp_checker import psp_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 session_active_o,
  input logic [TIME_BITS-1:0] target_time_o,
  input logic [PCT_BITS-1:0]  target_percent_o
);

  // a stalled result holds its target
  `PSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(target_time_o), "stalled result changed")

  // percent never passes full scale
  `PSP_ASSERT(a_pct_range, clk_i, rst_ni, !out_valid_o || target_percent_o <= PCT_BITS'(PERCENT_FULL), "percent above 100")

  // an inactive session reports a zero target and zero percent
  `PSP_ASSERT(a_idle_zero, clk_i, rst_ni, !out_valid_o || session_active_o || (target_time_o == '0 && target_percent_o == '0), "inactive session with nonzero target")

  // each input transfer occupies the sequencer for the next cycle
  `PSP_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "no stall after input transfer")

endmodule

bind proportional_seek_position_unit psp_checker #(.TIME_BITS(TIME_BITS)) u_psp_checker (.*);
